[src/shb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_pkg: shared types and constants of the string hash bucket unit
// Item and result structures, hashing constants, register map and the
// operation codes of the shared multiplier.
// ----------------------------------------------------------------------------
package shb_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned HASH_W   = 53;
    localparam int unsigned HIGH_W   = HASH_W - WORD_W;
    localparam int unsigned BUCKET_W = 8;
    localparam int unsigned ADDR_W   = 3;

    localparam logic [WORD_W-1:0] START_ONE  = 32'hdeadbeef;
    localparam logic [WORD_W-1:0] START_TWO  = 32'h41c6ce57;
    localparam logic [WORD_W-1:0] MUL_ONE    = 32'd2654435761;
    localparam logic [WORD_W-1:0] MUL_TWO    = 32'd1597334677;
    localparam logic [WORD_W-1:0] MIX_A      = 32'd2246822507;
    localparam logic [WORD_W-1:0] MIX_B      = 32'd3266489909;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'h00023ab8;

    localparam logic REG_SEED = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] key_byte;
        logic              byte_present;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [HASH_W-1:0]   hash_value;
        logic [BUCKET_W-1:0] bucket;
    } result_t;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_13   = 2'd1,
        SH_16   = 2'd2
    } shift_sel_t;

    typedef enum logic [1:0] {
        K_ONE   = 2'd0,
        K_TWO   = 2'd1,
        K_MIX_A = 2'd2,
        K_MIX_B = 2'd3
    } mul_const_t;

    typedef struct packed {
        logic [WORD_W-1:0] operand;
        shift_sel_t        shift;
        mul_const_t        mult;
    } mul_req_t;

endpackage

[src/shb_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_mul: shared xor-shift multiplier
// Optionally folds the operand with a right-shifted copy of itself and multiplies it,
// modulo 2^32, by one of the four hashing constants.
// ----------------------------------------------------------------------------
module shb_mul
    import shb_pkg::*;
(
    input  mul_req_t          req,
    output logic [WORD_W-1:0] product
);

    logic [WORD_W-1:0]   mixed;
    logic [WORD_W-1:0]   factor;
    logic [2*WORD_W-1:0] full;

    always_comb
    begin
        unique case (req.shift)
            SH_13:   mixed = req.operand ^ (req.operand >> 13);
            SH_16:   mixed = req.operand ^ (req.operand >> 16);
            default: mixed = req.operand;
        endcase
    end

    always_comb
    begin
        unique case (req.mult)
            K_ONE:   factor = MUL_ONE;
            K_TWO:   factor = MUL_TWO;
            K_MIX_A: factor = MIX_A;
            K_MIX_B: factor = MIX_B;
            default: factor = MUL_ONE;
        endcase
    end

    assign full    = {{WORD_W{1'b0}}, mixed} * {{WORD_W{1'b0}}, factor};
    assign product = full[WORD_W-1:0];

endmodule

[src/shb_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_mod: remainder unit
// Reduces the 53-bit hash modulo the bucket count one byte at a time, most
// significant byte first: a reciprocal multiplication estimates the quotient
// and a multiply-back with one correcting subtraction gives the partial
// remainder.
// ----------------------------------------------------------------------------
module shb_mod
    import shb_pkg::*;
#(
    parameter int unsigned BUCKET_COUNT = 255
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [HASH_W-1:0]   value,
    output logic [HASH_W-1:0]   hash,
    output logic [BUCKET_W-1:0] remainder,
    output logic                done
);

    localparam int unsigned DIGITS  = (HASH_W + BYTE_W - 1) / BYTE_W;
    localparam int unsigned PAD_W   = DIGITS * BYTE_W;
    localparam int unsigned PART_W  = BUCKET_W + BYTE_W;
    localparam int unsigned RECIP_W = 24;
    localparam int unsigned CNT_W   = $clog2(DIGITS);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_W) / 64'(BUCKET_COUNT));
    localparam logic [BUCKET_W-1:0] DIVISOR    = BUCKET_W'(BUCKET_COUNT);
    localparam logic [CNT_W-1:0]    LAST_DIGIT = CNT_W'(DIGITS - 1);

    logic [HASH_W-1:0]          hash_reg;
    logic [PAD_W-1:0]           digits_reg;
    logic [BUCKET_W-1:0]        rem_reg, rem_next;
    logic [PART_W-1:0]          part_reg;
    logic [PART_W-1:0]          quot_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       phase_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [PART_W-1:0]          part;
    logic [PART_W+RECIP_W-1:0]  recip_prod;
    logic [PART_W+BUCKET_W-1:0] back_prod;
    logic [PART_W-1:0]          diff;
    logic [PART_W-1:0]          wide_div;

    assign wide_div   = {{BYTE_W{1'b0}}, DIVISOR};
    assign part       = {rem_reg, digits_reg[PAD_W-1 -: BYTE_W]};
    assign recip_prod = {{RECIP_W{1'b0}}, part} * {{PART_W{1'b0}}, RECIP};
    assign back_prod  = {{BUCKET_W{1'b0}}, quot_reg} * {{PART_W{1'b0}}, DIVISOR};
    assign diff       = part_reg - back_prod[PART_W-1:0];

    always_comb
    begin
        if (diff >= wide_div)
        begin
            rem_next = BUCKET_W'(diff - wide_div);
        end
        else
        begin
            rem_next = diff[BUCKET_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                phase_reg <= 1'b1;
            end
            else
            begin
                phase_reg <= 1'b0;
                if (cnt_reg == LAST_DIGIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hash_reg   <= value;
            digits_reg <= {{(PAD_W-HASH_W){1'b0}}, value};
            rem_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                part_reg   <= part;
                quot_reg   <= recip_prod[PART_W+RECIP_W-1:RECIP_W];
                digits_reg <= digits_reg << BYTE_W;
            end
            else
            begin
                rem_reg <= rem_next;
            end
        end
    end

    assign hash      = hash_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

[src/string_hash_bucket_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_bucket_unit: cyrb53 string hash with bucket index
// Hashes a key given one byte per item and returns the 53-bit hash and its
// bucket index for the final item of each key.
// ----------------------------------------------------------------------------
// A key enters on the item channel one byte per item; last marks its end.
// For an item with a byte, the shared multiplier updates the first
// accumulator in the accepting cycle and the second one in the next cycle.
// An item without a byte and without last changes nothing and leaves the block ready.
// A last item then runs four finalisation multiplies through the same
// multiplier and a remainder over the seven bytes of the hash; the next item
// is taken once the result has been written to the free output register.
// item_stall is high while an item is at work.
// The result sits in an output register until it is taken; the block accepts
// further items meanwhile, and only a following last item waits for it.
// Reset and every write of the seed register reload both accumulators from
// the seed; the seed resets to 0x23ab8. No memory is used.
// ----------------------------------------------------------------------------
module string_hash_bucket_unit
    import shb_pkg::*;
#(
    parameter int unsigned BUCKET_COUNT = 255
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ABSORB = 7'b0000010,
        S_FIN1   = 7'b0000100,
        S_FIN2   = 7'b0001000,
        S_FIN3   = 7'b0010000,
        S_FIN4   = 7'b0100000,
        S_MOD    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [WORD_W-1:0]   seed_reg;
    logic [WORD_W-1:0]   acc_one_reg, acc_one_next;
    logic [WORD_W-1:0]   acc_two_reg, acc_two_next;
    logic [WORD_W-1:0]   tmp_reg, tmp_next;
    logic [BYTE_W-1:0]   byte_reg;
    logic                last_reg;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;
    mul_req_t            req;
    logic [WORD_W-1:0]   product;
    logic                mod_start;
    logic [HASH_W-1:0]   mod_hash;
    logic [BUCKET_W-1:0] mod_rem;
    logic                mod_done;
    logic                seed_write;
    logic                item_accept;
    logic                slot_free;

    shb_mul u_mul
    (
        .req     (req),
        .product (product)
    );

    shb_mod #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .value     ({acc_two_next[HIGH_W-1:0], acc_one_reg}),
        .hash      (mod_hash),
        .remainder (mod_rem),
        .done      (mod_done)
    );

    assign pready      = 1'b1;
    assign seed_write  = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SEED);
    assign prdata      = (paddr[ADDR_W-1] == REG_SEED) ? seed_reg : '0;
    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign slot_free   = !result_valid_reg || !result_stall;
    assign mod_start   = (state_reg == S_FIN4);

    always_comb
    begin
        req.operand = acc_one_reg ^ {{(WORD_W-BYTE_W){1'b0}}, item.key_byte};
        req.shift   = SH_NONE;
        req.mult    = K_ONE;
        unique case (state_reg)
            S_ABSORB:
            begin
                req.operand = acc_two_reg ^ {{(WORD_W-BYTE_W){1'b0}}, byte_reg};
                req.mult    = K_TWO;
            end
            S_FIN1:
            begin
                req.operand = acc_one_reg;
                req.shift   = SH_16;
                req.mult    = K_MIX_A;
            end
            S_FIN2:
            begin
                req.operand = acc_two_reg;
                req.shift   = SH_13;
                req.mult    = K_MIX_B;
            end
            S_FIN3:
            begin
                req.operand = acc_two_reg;
                req.shift   = SH_16;
                req.mult    = K_MIX_A;
            end
            S_FIN4:
            begin
                req.operand = acc_one_reg;
                req.shift   = SH_13;
                req.mult    = K_MIX_B;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        acc_one_next      = acc_one_reg;
        acc_two_next      = acc_two_reg;
        tmp_next          = tmp_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    if (item.byte_present)
                    begin
                        acc_one_next = product;
                        state_next   = S_ABSORB;
                    end
                    else if (item.last)
                    begin
                        state_next = S_FIN1;
                    end
                end
            end
            S_ABSORB:
            begin
                acc_two_next = product;
                state_next   = last_reg ? S_FIN1 : S_IDLE;
            end
            S_FIN1:
            begin
                tmp_next   = product;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                acc_one_next = tmp_reg ^ product;
                state_next   = S_FIN3;
            end
            S_FIN3:
            begin
                tmp_next   = product;
                state_next = S_FIN4;
            end
            S_FIN4:
            begin
                acc_two_next = tmp_reg ^ product;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                if (mod_done && slot_free)
                begin
                    result_next.hash_value = mod_hash;
                    result_next.bucket     = mod_rem;
                    result_valid_next      = 1'b1;
                    acc_one_next           = START_ONE ^ seed_reg;
                    acc_two_next           = START_TWO ^ seed_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            seed_reg         <= SEED_RESET;
            acc_one_reg      <= START_ONE ^ SEED_RESET;
            acc_two_reg      <= START_TWO ^ SEED_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (seed_write)
            begin
                seed_reg    <= pwdata;
                acc_one_reg <= START_ONE ^ pwdata;
                acc_two_reg <= START_TWO ^ pwdata;
            end
            else
            begin
                acc_one_reg <= acc_one_next;
                acc_two_reg <= acc_two_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg    <= tmp_next;
        result_reg <= result_next;
        if (item_accept)
        begin
            byte_reg <= item.key_byte;
            last_reg <= item.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[src/shb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shb_checker: port-level checks of the string hash bucket unit
// Watches the item and result channels and flags breaches of the expected
// sequencing and result range.
// ----------------------------------------------------------------------------
module shb_checker
    import shb_pkg::*;
#(
    parameter int unsigned BUCKET_COUNT = 255
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    localparam logic [BUCKET_W-1:0] BUCKET_LIMIT = BUCKET_W'(BUCKET_COUNT);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("Stalled result item changed or was dropped.");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.bucket < BUCKET_LIMIT)
        else $error("Bucket index is not below the bucket count.");

    a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.byte_present |=> item_stall)
        else $error("Block took no second cycle for a byte item.");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.last |=> item_stall)
        else $error("Block was ready straight after a last item.");

    a_last_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.last && !result_valid |=> !result_valid)
        else $error("Result item appeared before finalisation could finish.");

endmodule

bind string_hash_bucket_unit shb_checker #(
    .BUCKET_COUNT (BUCKET_COUNT)
) u_shb_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the string hash bucket unit
// Keys are fed one byte per item under random idling and a long result
// hold-off. A tracker mirrors both accumulators and the finalisation and
// checks each hash and bucket index in order, across several seed values.
// ----------------------------------------------------------------------------
module tb_top;
    import shb_pkg::*;

    localparam int unsigned BUCKETS       = 255;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned HOLDOFF       = 400;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam logic [ADDR_W-1:0] SEED_ADDR = ADDR_W'(4 * int'(REG_SEED));

    class key_hash_tracker;
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] acc_one;
        logic [WORD_W-1:0] acc_two;
        int unsigned       bucket_mod;
        result_t           hashes_due[$];
        int unsigned       hashes_checked;
        int unsigned       faults;

        function new(int unsigned buckets);
            bucket_mod     = buckets;
            seed           = SEED_RESET;
            hashes_checked = 0;
            faults         = 0;
            restart();
        endfunction

        function void restart();
            acc_one = START_ONE ^ seed;
            acc_two = START_TWO ^ seed;
        endfunction

        function void load_seed(logic [WORD_W-1:0] value);
            seed = value;
            restart();
        endfunction

        function void absorb_item(item_t it);
            logic [WORD_W-1:0] f1;
            logic [WORD_W-1:0] f2;
            logic [63:0]       full;
            result_t           due;
            if (it.byte_present)
            begin
                acc_one = (acc_one ^ {24'd0, it.key_byte}) * MUL_ONE;
                acc_two = (acc_two ^ {24'd0, it.key_byte}) * MUL_TWO;
            end
            if (it.last)
            begin
                f1 = acc_one;
                f2 = acc_two;
                f1 = (f1 ^ (f1 >> 16)) * MIX_A;
                f1 = f1 ^ ((f2 ^ (f2 >> 13)) * MIX_B);
                f2 = (f2 ^ (f2 >> 16)) * MIX_A;
                f2 = f2 ^ ((f1 ^ (f1 >> 13)) * MIX_B);
                full = {11'd0, f2[HIGH_W-1:0], f1};
                due.hash_value = full[HASH_W-1:0];
                due.bucket     = BUCKET_W'(full % 64'(bucket_mod));
                hashes_due.push_back(due);
                restart();
            end
        endfunction

        function void check_hash(result_t got);
            result_t want;
            if (hashes_due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("Unexpected hash result: hash %h bucket %0d",
                             got.hash_value, got.bucket);
                return;
            end
            want = hashes_due.pop_front();
            hashes_checked++;
            if (got.hash_value !== want.hash_value || got.bucket !== want.bucket)
            begin
                faults++;
                if (faults <= 10)
                    $display("Hash mismatch: expected %h/%0d, got %h/%0d",
                             want.hash_value, want.bucket, got.hash_value, got.bucket);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    item_t             item;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [WORD_W-1:0] pwdata;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    key_hash_tracker tracker = new(BUCKETS);
    bit              quiet;
    bit              hold_req;
    int unsigned     cycle_count;
    int unsigned     item_count;
    int unsigned     key_count;
    int unsigned     seed_settings;

    string_hash_bucket_unit #(.BUCKET_COUNT(BUCKETS)) u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run exceeded %0d cycles.", CYCLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned holdoff_left;
        holdoff_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                tracker.check_hash(result);
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                result_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req     = 1'b0;
                holdoff_left = HOLDOFF;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !quiet && ($urandom_range(99) < 11);
        end
    end

    function automatic item_t make_item(logic [7:0] b, logic present, logic last);
        item_t it;
        it.key_byte     = b;
        it.byte_present = present;
        it.last         = last;
        return it;
    endfunction

    task automatic offer_item(input item_t it);
        int unsigned gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(99) < 11)
                gap++;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        tracker.absorb_item(it);
        if (it.byte_present || it.last)
            item_count++;
        if (it.last)
            key_count++;
    endtask

    task automatic send_key(input int unsigned len, input bit end_marker);
        item_t it;
        for (int unsigned i = 0; i < len; i++)
        begin
            it.key_byte     = 8'($urandom_range(255));
            it.byte_present = ($urandom_range(99) < 92);
            it.last         = (i == len - 1) && !end_marker;
            offer_item(it);
            if ($urandom_range(99) < 5)
                offer_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
        end
        if (end_marker || len == 0)
            offer_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
    endtask

    task automatic random_phase(input int unsigned quota);
        int unsigned target;
        int unsigned len;
        target = item_count + quota;
        while (item_count < target)
        begin
            if ($urandom_range(99) < 8)
                len = $urandom_range(40, 16);
            else
                len = $urandom_range(12, 0);
            send_key(len, $urandom_range(99) < 20);
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (tracker.hashes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.load_seed(value);
        seed_settings++;
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        seed_settings = 1;

        // Empty key, an ignored item, then the empty key again.
        offer_item(make_item(8'h00, 1'b0, 1'b1));
        offer_item(make_item(8'ha5, 1'b0, 1'b0));
        offer_item(make_item(8'h00, 1'b0, 1'b1));
        // A byte on the final item is absorbed before finalisation.
        offer_item(make_item(8'h00, 1'b1, 1'b1));
        offer_item(make_item(8'hff, 1'b1, 1'b1));
        offer_item(make_item(8'h61, 1'b1, 1'b0));
        offer_item(make_item(8'h62, 1'b1, 1'b0));
        offer_item(make_item(8'h63, 1'b1, 1'b1));
        offer_item(make_item(8'h41, 1'b1, 1'b0));
        offer_item(make_item(8'h7f, 1'b0, 1'b0));
        offer_item(make_item(8'h80, 1'b1, 1'b0));
        offer_item(make_item(8'h00, 1'b0, 1'b1));
        offer_item(make_item(8'hff, 1'b1, 1'b0));
        offer_item(make_item(8'hff, 1'b1, 1'b0));
        offer_item(make_item(8'hff, 1'b1, 1'b0));
        offer_item(make_item(8'hff, 1'b1, 1'b0));
        offer_item(make_item(8'h01, 1'b1, 1'b1));
        offer_item(make_item(8'h55, 1'b1, 1'b0));
        offer_item(make_item(8'haa, 1'b1, 1'b0));
        offer_item(make_item(8'h5a, 1'b1, 1'b1));
        // A partly absorbed key is dropped by the next seed write.
        offer_item(make_item(8'h12, 1'b1, 1'b0));
        offer_item(make_item(8'h34, 1'b1, 1'b0));
        settle();

        write_seed('0);
        random_phase(120);
        settle();

        write_seed('1);
        hold_req = 1'b1;
        random_phase(120);
        settle();

        write_seed($urandom);
        quiet = 1'b1;
        random_phase(120);
        settle();

        quiet = 1'b0;
        write_seed($urandom);
        random_phase(120);
        settle();

        $display("Sent %0d items forming %0d keys under %0d seed values.",
                 item_count, key_count, seed_settings);
        $display("Checked %0d hashes; %0d faults, %0d hashes outstanding.",
                 tracker.hashes_checked, tracker.faults, tracker.hashes_due.size());
        if (tracker.faults == 0 && tracker.hashes_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
